FILE: rtl/core/conv_threshold_highlight_defines.svh
// Assertion helpers for the top-level RTL file.
`ifndef CONV_THRESHOLD_HIGHLIGHT_DEFINES_SVH
`define CONV_THRESHOLD_HIGHLIGHT_DEFINES_SVH

// Checked only outside reset.
`define CTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define CTC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/ctc_pkg.sv
package ctc_pkg;

  localparam int KERNEL_SIZE = 3;
  localparam int MAX_WIDTH   = 1024;
  localparam int COEF_BITS   = 8;
  localparam int TAPS        = KERNEL_SIZE * KERNEL_SIZE;
  localparam int PIX_W       = 24;
  localparam int COL_W       = 10;
  localparam int ROW_W       = 12;
  localparam int WID_W       = 11;
  localparam int SUM_W       = 20;
  localparam int DEN_W       = 12;
  localparam int ADDR_W      = 5;

  localparam logic [ROW_W-1:0] ROW_MAX = 12'd4095;

  // Register indexes (paddr[4:2])
  localparam logic [2:0] REG_COEF_TOP = 3'd0;
  localparam logic [2:0] REG_COEF_MID = 3'd1;
  localparam logic [2:0] REG_COEF_BOT = 3'd2;
  localparam logic [2:0] REG_WIDTH    = 3'd3;
  localparam logic [2:0] REG_THRESH   = 3'd4;

  typedef struct packed {
    logic       start_of_frame;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } in_item_t;

  typedef struct packed {
    logic [COL_W-1:0] center_col;
    logic [ROW_W-1:0] center_row;
    logic [7:0]       out_red;
    logic [7:0]       out_green;
    logic [7:0]       out_blue;
    logic             highlighted;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic ack;
  } flt_ctl_t;

  typedef struct packed {
    logic done;
    logic hi;
  } flt_res_t;

endpackage

FILE: rtl/core/ctc_line_mem.sv
module ctc_line_mem (
  input  logic                        clk,
  input  logic                        re,
  input  logic [ctc_pkg::COL_W-1:0]   raddr,
  output logic [2*ctc_pkg::PIX_W-1:0] rdata,
  input  logic                        we,
  input  logic [ctc_pkg::COL_W-1:0]   waddr,
  input  logic [2*ctc_pkg::PIX_W-1:0] wdata
);

  // Both line stores side by side: low half newest line, high half older line
  logic [2*ctc_pkg::PIX_W-1:0] mem [ctc_pkg::MAX_WIDTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/ctc_filter.sv
module ctc_filter (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  ctc_pkg::flt_ctl_t                         ctl,
  input  logic [ctc_pkg::TAPS*ctc_pkg::PIX_W-1:0]   win,
  input  logic [3*3*ctc_pkg::COEF_BITS-1:0]         coefs,
  input  logic [7:0]                                threshold,
  output ctc_pkg::flt_res_t                         res
);

  typedef enum logic [2:0] {F_IDLE, F_MAC, F_NORM, F_DIV, F_DONE} fst_t;

  fst_t                               st_r;
  logic [3:0]                         tap_r;
  logic signed [ctc_pkg::SUM_W-1:0]   acc_r [3];
  logic signed [ctc_pkg::DEN_W-1:0]   den_r;
  logic [ctc_pkg::SUM_W-1:0]          rem_r;
  logic [ctc_pkg::DEN_W-1:0]          dv_r;
  logic [7:0]                         q_r;
  logic [2:0]                         bit_r;

  logic signed [ctc_pkg::COEF_BITS-1:0] coef;
  logic signed [16:0]                   prod [3];
  logic signed [ctc_pkg::SUM_W-1:0]     peak;
  logic [ctc_pkg::DEN_W-1:0]            absden;
  logic [ctc_pkg::SUM_W:0]              lim;
  logic [ctc_pkg::SUM_W:0]              dsh;

  // Tap products, one tap per cycle
  always_comb begin
    coef = $signed(coefs[tap_r*ctc_pkg::COEF_BITS +: ctc_pkg::COEF_BITS]);
    for (int k = 0; k < 3; k++) begin
      prod[k] = coef * $signed({1'b0, win[tap_r*ctc_pkg::PIX_W + 8*k +: 8]});
    end
  end

  // Peak and denominator magnitude
  always_comb begin
    peak = acc_r[0];
    if (acc_r[1] > peak) peak = acc_r[1];
    if (acc_r[2] > peak) peak = acc_r[2];
    if (den_r == '0) begin
      absden = ctc_pkg::DEN_W'(1);
    end else if (den_r < 0) begin
      absden = ctc_pkg::DEN_W'(-den_r);
    end else begin
      absden = ctc_pkg::DEN_W'(den_r);
    end
    lim = (ctc_pkg::SUM_W+1)'(absden) << 8;
    dsh = (ctc_pkg::SUM_W+1)'(dv_r) << bit_r;
  end

  // Sequence MAC, normalize and restoring divide
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= F_IDLE;
      tap_r <= '0;
      bit_r <= '0;
    end else begin
      case (st_r)
        F_IDLE: begin
          if (ctl.start) begin
            st_r  <= F_MAC;
            tap_r <= '0;
            den_r <= '0;
            for (int k = 0; k < 3; k++) acc_r[k] <= '0;
          end
        end
        F_MAC: begin
          for (int k = 0; k < 3; k++) acc_r[k] <= acc_r[k] + ctc_pkg::SUM_W'(prod[k]);
          den_r <= den_r + ctc_pkg::DEN_W'(coef);
          if (tap_r == 4'(ctc_pkg::TAPS - 1)) begin
            st_r <= F_NORM;
          end else begin
            tap_r <= tap_r + 4'd1;
          end
        end
        F_NORM: begin
          dv_r <= absden;
          if (peak <= 0) begin
            q_r  <= 8'd0;
            st_r <= F_DONE;
          end else if ((ctc_pkg::SUM_W+1)'(peak) >= lim) begin
            q_r  <= 8'd255;
            st_r <= F_DONE;
          end else begin
            rem_r <= ctc_pkg::SUM_W'(peak);
            q_r   <= 8'd0;
            bit_r <= 3'd7;
            st_r  <= F_DIV;
          end
        end
        F_DIV: begin
          if ((ctc_pkg::SUM_W+1)'(rem_r) >= dsh) begin
            rem_r        <= ctc_pkg::SUM_W'((ctc_pkg::SUM_W+1)'(rem_r) - dsh);
            q_r[bit_r]   <= 1'b1;
          end
          if (bit_r == 3'd0) begin
            st_r <= F_DONE;
          end else begin
            bit_r <= bit_r - 3'd1;
          end
        end
        F_DONE: begin
          if (ctl.ack) st_r <= F_IDLE;
        end
        default: st_r <= F_IDLE;
      endcase
    end
  end

  assign res.done = (st_r == F_DONE);
  assign res.hi   = (q_r > threshold);

endmodule

FILE: rtl/core/conv_threshold_highlight.sv
// 3x3 filter with threshold highlight over a raster RGB stream. One request is
// taken at a time: a border pixel passes through accept, line store read and
// window update; an interior pixel then adds the tap products on one shared
// multiplier set, a normalize step, a bit-serial division (skipped when the
// result is zero or saturates) and a handoff. The finished result waits in an
// output register, so the next request is taken while it is pending. Line
// store contents are undefined until a full line has been written.
`include "conv_threshold_highlight_defines.svh"

module conv_threshold_highlight (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  ctc_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output ctc_pkg::out_item_t          out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ctc_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  typedef enum logic [1:0] {S_IDLE, S_RD, S_UPD, S_CALC} st_t;

  st_t                          state_r;
  logic [23:0]                  coef_top_r, coef_mid_r, coef_bot_r;
  logic [ctc_pkg::WID_W-1:0]    width_r;
  logic [7:0]                   thresh_r;
  logic [ctc_pkg::COL_W-1:0]    colcnt_r, col_r;
  logic [ctc_pkg::ROW_W-1:0]    rowcnt_r, row_r;
  logic [ctc_pkg::PIX_W-1:0]    px_r;
  logic                         prod_r;
  logic [ctc_pkg::PIX_W-1:0]    win_r [ctc_pkg::TAPS];
  logic                         out_valid_r;
  ctc_pkg::out_item_t           out_data_r;

  logic                         accept, load;
  logic [ctc_pkg::WID_W-1:0]    wid;
  logic [ctc_pkg::COL_W-1:0]    cc, col_now;
  logic [ctc_pkg::ROW_W-1:0]    row_now;
  logic [ctc_pkg::WID_W-1:0]    col_inc;
  logic [2*ctc_pkg::PIX_W-1:0]  rdata;
  logic [ctc_pkg::TAPS*ctc_pkg::PIX_W-1:0] win_flat;
  ctc_pkg::flt_ctl_t            flt_ctl;
  ctc_pkg::flt_res_t            flt_res;
  logic [2:0]                   reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_top_r <= 24'd0;
      coef_mid_r <= 24'd256;
      coef_bot_r <= 24'd0;
      width_r    <= 11'd1024;
      thresh_r   <= 8'd255;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        ctc_pkg::REG_COEF_TOP: coef_top_r <= pwdata[23:0];
        ctc_pkg::REG_COEF_MID: coef_mid_r <= pwdata[23:0];
        ctc_pkg::REG_COEF_BOT: coef_bot_r <= pwdata[23:0];
        ctc_pkg::REG_WIDTH:    width_r    <= pwdata[ctc_pkg::WID_W-1:0];
        ctc_pkg::REG_THRESH:   thresh_r   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (reg_idx)
      ctc_pkg::REG_COEF_TOP: prdata = {8'd0, coef_top_r};
      ctc_pkg::REG_COEF_MID: prdata = {8'd0, coef_mid_r};
      ctc_pkg::REG_COEF_BOT: prdata = {8'd0, coef_bot_r};
      ctc_pkg::REG_WIDTH:    prdata = {21'd0, width_r};
      ctc_pkg::REG_THRESH:   prdata = {24'd0, thresh_r};
      default:               prdata = 32'd0;
    endcase
  end

  // Position of the incoming pixel
  always_comb begin
    if (width_r < 11'(ctc_pkg::KERNEL_SIZE)) begin
      wid = 11'(ctc_pkg::KERNEL_SIZE);
    end else if (width_r > 11'(ctc_pkg::MAX_WIDTH)) begin
      wid = 11'(ctc_pkg::MAX_WIDTH);
    end else begin
      wid = width_r;
    end
    cc      = in_data.start_of_frame ? '0 : colcnt_r;
    row_now = in_data.start_of_frame ? '0 : rowcnt_r;
    col_now = ({1'b0, cc} >= wid) ? '0 : cc;
    col_inc = {1'b0, col_now} + 11'd1;
  end

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign load      = (state_r == S_CALC) && flt_res.done && (!out_valid_r || !out_stall);
  assign flt_ctl.start = (state_r == S_UPD) && prod_r;
  assign flt_ctl.ack   = load;

  // Request sequencing, counters and window
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      colcnt_r <= '0;
      rowcnt_r <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            col_r  <= col_now;
            row_r  <= row_now;
            px_r   <= {in_data.in_blue, in_data.in_green, in_data.in_red};
            prod_r <= (row_now >= 12'(ctc_pkg::KERNEL_SIZE - 1)) &&
                      (col_now >= 10'(ctc_pkg::KERNEL_SIZE - 1));
            if (col_inc >= wid) begin
              colcnt_r <= '0;
              rowcnt_r <= (row_now < ctc_pkg::ROW_MAX) ? row_now + 12'd1 : row_now;
            end else begin
              colcnt_r <= col_inc[ctc_pkg::COL_W-1:0];
              rowcnt_r <= row_now;
            end
            state_r <= S_RD;
          end
        end
        S_RD: state_r <= S_UPD;
        S_UPD: begin
          // shift window left, new column enters on the right
          for (int r = 0; r < 3; r++) begin
            win_r[r*3]     <= win_r[r*3 + 1];
            win_r[r*3 + 1] <= win_r[r*3 + 2];
          end
          win_r[2] <= rdata[2*ctc_pkg::PIX_W-1:ctc_pkg::PIX_W];
          win_r[5] <= rdata[ctc_pkg::PIX_W-1:0];
          win_r[8] <= px_r;
          state_r  <= prod_r ? S_CALC : S_IDLE;
        end
        S_CALC: begin
          if (load) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      out_data_r.center_col  <= col_r - 10'd1;
      out_data_r.center_row  <= row_r - 12'd1;
      out_data_r.out_red     <= flt_res.hi ? 8'd0   : win_r[4][7:0];
      out_data_r.out_green   <= flt_res.hi ? 8'd255 : win_r[4][15:8];
      out_data_r.out_blue    <= flt_res.hi ? 8'd255 : win_r[4][23:16];
      out_data_r.highlighted <= flt_res.hi;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  for (genvar t = 0; t < ctc_pkg::TAPS; t++) begin : g_flat
    assign win_flat[t*ctc_pkg::PIX_W +: ctc_pkg::PIX_W] = win_r[t];
  end

  ctc_line_mem u_mem (
    .clk   (clk),
    .re    (accept),
    .raddr (col_now),
    .rdata (rdata),
    .we    (state_r == S_UPD),
    .waddr (col_r),
    .wdata ({rdata[ctc_pkg::PIX_W-1:0], px_r})
  );

  ctc_filter u_flt (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (flt_ctl),
    .win       (win_flat),
    .coefs     ({coef_bot_r, coef_mid_r, coef_top_r}),
    .threshold (thresh_r),
    .res       (flt_res)
  );

  `CTC_ASSERT(a_accept_reads, accept |=> (state_r == S_RD), "accepted request did not start read")
  `CTC_ASSERT(a_calc_interior, (state_r == S_CALC) |-> prod_r, "filter run for border pixel")
  `CTC_ASSERT(a_out_from_filter, $rose(out_valid) |-> $past(flt_res.done), "result without filter")
  `CTC_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (state_r == S_IDLE && !out_valid), "reset not idle")

endmodule

FILE: test/highlight_checker.sv
module highlight_checker
  import ctc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  in_item_t            in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  out_item_t           out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [31:0]         pwdata,
  input  logic                pready,
  output int                  fail_count,
  output int                  pending
);

  // Shadow copy of the programmed registers
  logic [23:0]      coef_rows [3];
  logic [WID_W-1:0] line_width;
  logic [7:0]       thresh_level;

  // Shadow copy of the filter state
  logic [PIX_W-1:0] recent_line [MAX_WIDTH];
  logic [PIX_W-1:0] older_line [MAX_WIDTH];
  logic [PIX_W-1:0] window_px [3][3];
  int               col_pos;
  int               row_pos;

  out_item_t expected_pixels[$];

  assign pending = expected_pixels.size();

  // Advance the filter model by one request, queue a result for interior pixels
  task automatic predict_pixel(input in_item_t px_in);
    int               w;
    int               col;
    int               row;
    int               den;
    int               peak;
    int               level;
    int               wgt;
    int               sums [3];
    logic signed [7:0] c8;
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] center;
    out_item_t        res;
    w = int'(line_width);
    if (w < KERNEL_SIZE) w = KERNEL_SIZE;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    if (px_in.start_of_frame) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (col_pos >= w) col_pos = 0;
    col = col_pos;
    row = row_pos;
    px = {px_in.in_blue, px_in.in_green, px_in.in_red};

    // shift window left, new column enters on the right
    for (int r = 0; r < 3; r++) begin
      window_px[r][0] = window_px[r][1];
      window_px[r][1] = window_px[r][2];
    end
    window_px[0][2] = older_line[col];
    window_px[1][2] = recent_line[col];
    window_px[2][2] = px;
    older_line[col] = recent_line[col];
    recent_line[col] = px;

    if (row >= 2 && col >= 2) begin
      den = 0;
      sums = '{0, 0, 0};
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++) begin
          c8 = coef_rows[r][8*c +: 8];
          wgt = c8;
          den += wgt;
          for (int k = 0; k < 3; k++)
            sums[k] += wgt * int'(window_px[r][c][8*k +: 8]);
        end
      if (den == 0) den = 1;
      if (den < 0) den = -den;
      peak = sums[0];
      if (sums[1] > peak) peak = sums[1];
      if (sums[2] > peak) peak = sums[2];
      level = peak / den;
      if (level > 255) level = 255;
      if (level < 0) level = 0;
      center = window_px[1][1];
      res.center_col = COL_W'(col - 1);
      res.center_row = ROW_W'(row - 1);
      res.highlighted = (level > int'(thresh_level));
      res.out_red   = res.highlighted ? 8'd0 : center[7:0];
      res.out_green = res.highlighted ? 8'd255 : center[15:8];
      res.out_blue  = res.highlighted ? 8'd255 : center[23:16];
      expected_pixels.push_back(res);
    end

    if (col + 1 >= w) begin
      col_pos = 0;
      if (row_pos < int'(ROW_MAX)) row_pos++;
    end else begin
      col_pos = col + 1;
    end
  endtask

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t exp_px;
    if (!rst_n) begin
      coef_rows[0] <= 24'd0;
      coef_rows[1] <= 24'd256;
      coef_rows[2] <= 24'd0;
      line_width   <= WID_W'(1024);
      thresh_level <= 8'd255;
      col_pos = 0;
      row_pos = 0;
      fail_count = 0;
    end else begin
      // track register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_COEF_TOP: coef_rows[0] <= pwdata[23:0];
          REG_COEF_MID: coef_rows[1] <= pwdata[23:0];
          REG_COEF_BOT: coef_rows[2] <= pwdata[23:0];
          REG_WIDTH:    line_width   <= pwdata[WID_W-1:0];
          REG_THRESH:   thresh_level <= pwdata[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_pixel(in_data);
      // compare each delivered result with the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
          fail_count++;
        end else begin
          exp_px = expected_pixels.pop_front();
          check_field("center_col", exp_px.center_col, out_data.center_col);
          check_field("center_row", exp_px.center_row, out_data.center_row);
          check_field("out_red", exp_px.out_red, out_data.out_red);
          check_field("out_green", exp_px.out_green, out_data.out_green);
          check_field("out_blue", exp_px.out_blue, out_data.out_blue);
          check_field("highlighted", exp_px.highlighted, out_data.highlighted);
        end
      end
    end
  end

endmodule

FILE: test/tb_conv_threshold_highlight.sv
module tb_conv_threshold_highlight;
  import ctc_pkg::*;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_item_t          in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  int                fail_count;
  int                pending;
  bit                no_gaps;
  int                stall_left;
  int                random_sent;

  always #5 clk = ~clk;

  conv_threshold_highlight uut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  highlight_checker checker_i (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready, .fail_count, .pending
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver back-pressure: mostly short stalls, a few long ones
  always @(negedge clk) begin
    if (!rst_n || no_gaps) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      stall_left = gap_len();
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Issue one request, hold it until taken
  task automatic send_pixel(input bit sof, input [7:0] r, input [7:0] g, input [7:0] b);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data <= '{start_of_frame: sof, in_red: r, in_green: g, in_blue: b};
    in_valid <= 1'b1;
    #1;
    while (in_stall) begin
      @(negedge clk);
      #1;
    end
    @(negedge clk);
  endtask

  task automatic send_random(input bit sof);
    send_pixel(sof, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Drain all results and let a border pixel in flight finish
  task automatic settle();
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic write_kernel(input [23:0] top, input [23:0] mid, input [23:0] bot);
    write_reg(REG_COEF_TOP, top);
    write_reg(REG_COEF_MID, mid);
    write_reg(REG_COEF_BOT, bot);
  endtask

  // One frame of random pixels, optionally with a stray frame start inside
  task automatic send_frame(input int w, input int rows, input bit noisy, input bit counted);
    for (int i = 0; i < w * rows; i++) begin
      send_random(i == 0 || (noisy && $urandom_range(0, 60) == 0));
      if (counted) random_sent++;
    end
  endtask

  initial begin
    int w;
    no_gaps = 0;
    random_sent = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // border pixels only at reset settings: no results
    send_pixel(1'b1, 8'd0, 8'd0, 8'd0);
    send_pixel(1'b0, 8'd255, 8'd255, 8'd255);
    send_pixel(1'b0, 8'd255, 8'd0, 8'd255);
    settle();

    // narrow frame, identity kernel, threshold zero: bright pixels highlight
    write_reg(REG_WIDTH, 32'd0);
    write_reg(REG_THRESH, 32'd0);
    send_pixel(1'b1, 8'd255, 8'd255, 8'd255);
    for (int i = 1; i < 15; i++)
      send_pixel(1'b0, (i % 2) ? 8'd0 : 8'd255, (i % 3) ? 8'd255 : 8'd0, 8'(i * 17));
    settle();

    // most negative and most positive coefficients, highest threshold
    write_kernel(24'h808080, 24'h808080, 24'h808080);
    write_reg(REG_THRESH, 32'd255);
    send_frame(3, 3, 0, 0);
    settle();
    write_kernel(24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F);
    write_reg(REG_WIDTH, 32'd2);
    send_frame(3, 3, 0, 0);
    settle();

    // zero coefficient sum: divide by one
    write_kernel(24'h01FF00, 24'h000000, 24'h0001FF);
    write_reg(REG_THRESH, 32'd100);
    write_reg(REG_WIDTH, 32'd4);
    send_frame(4, 4, 0, 0);
    settle();

    // random phases of frames with random contents, some with stray frame starts
    while (random_sent < 600) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      w = ($urandom_range(0, 5) == 0) ? $urandom_range(3, 64) : $urandom_range(3, 12);
      write_kernel(24'($urandom), 24'($urandom), 24'($urandom));
      if ($urandom_range(0, 3) == 0)
        write_kernel(24'($urandom) & 24'h030303, 24'($urandom) & 24'h070707, 24'h0);
      write_reg(REG_WIDTH, w);
      write_reg(REG_THRESH, $urandom_range(0, 255));
      repeat ($urandom_range(1, 3))
        send_frame(w, $urandom_range(3, 7), $urandom_range(0, 3) == 0, 1);
      // unfinished frame, then a shrink of the width while mid-line
      if ($urandom_range(0, 2) == 0 && w > 3) begin
        send_frame(w, 3, 0, 1);
        repeat ($urandom_range(1, w - 1)) begin
          send_random(1'b0);
          random_sent++;
        end
        settle();
        write_reg(REG_WIDTH, $urandom_range(3, w - 1));
        repeat (3 * w) begin
          send_random(1'b0);
          random_sent++;
        end
      end
      settle();
    end
    no_gaps = 0;

    repeat (50) @(negedge clk);
    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
